// File: design/bucket_hash_table_overflow_chain_defines.svh
// Assertion macros shared by the hash table RTL.
// No dependencies; included by the top level, the only file that carries assertions.
`ifndef BUCKET_HASH_TABLE_OVERFLOW_CHAIN_DEFINES_SVH
`define BUCKET_HASH_TABLE_OVERFLOW_CHAIN_DEFINES_SVH

// same-cycle implication
`define BHTOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BHTOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/bhtoc_pkg.sv
// Types and constants of the bucket hash table.
// No dependencies.
package bhtoc_pkg;

  localparam int KEY_W      = 32;
  localparam int NB_W       = 7;
  localparam int NS_W       = 4;
  localparam int POS_W      = 10;
  localparam int READS_W    = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_KEYZERO  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BUCKETS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SLOTS = 1'b1;

  localparam logic [NB_W-1:0] NB_RESET = 7'd64;
  localparam logic [NS_W-1:0] NS_RESET = 4'd8;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_BASE, ST_RD, ST_CHK, ST_WR_NEW, ST_WR_TAIL, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PH_SCAN, PH_TAIL, PH_LOOK} phase_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [KEY_W-1:0] mag;
    logic [NB_W-1:0]  div;
  } rem_req_t;

  typedef struct packed {
    logic            done;
    logic [NB_W-1:0] bucket;
  } rem_rsp_t;

endpackage

// File: design/bhtoc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on bhtoc_pkg.
interface bhtoc_in_if import bhtoc_pkg::*; #(parameter int PW = 32);
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] key;
  logic [PW-1:0]    payload;
  modport source (output valid, opcode, key, payload, input ready);
  modport sink   (input valid, opcode, key, payload, output ready);
endinterface

interface bhtoc_out_if import bhtoc_pkg::*; #(parameter int PW = 32);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   position;
  logic [PW-1:0]      found_payload;
  logic [READS_W-1:0] entries_read;
  modport source (output valid, status, position, found_payload, entries_read, input ready);
  modport sink   (input valid, status, position, found_payload, entries_read, output ready);
endinterface

// File: design/bhtoc_rem.sv
// Bit-serial remainder unit: bucket = key mod num_buckets, non-negative.
// Depends on bhtoc_pkg. 32 iterations, one quotient bit per cycle.
module bhtoc_rem import bhtoc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);
  localparam int CNT_W = $clog2(KEY_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] dvd_r, dvd_nxt;
  logic [NB_W-1:0]  rem_r, rem_nxt;
  logic [NB_W-1:0]  div_r, div_nxt;
  logic             neg_r, neg_nxt;
  logic [NB_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, dvd_r[KEY_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.mag;
      rem_nxt  = '0;
      div_nxt  = req.div;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) rem_nxt = NB_W'(trial - {1'b0, div_r});
      else rem_nxt = NB_W'(trial);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  // negative key with nonzero remainder wraps to divisor - remainder
  assign rsp.done   = done_r;
  assign rsp.bucket = (neg_r && rem_r != '0) ? div_r - rem_r : rem_r;

endmodule

// File: design/bhtoc_mem.sv
// Single-port record store: key with link word, and payload.
// Depends on bhtoc_pkg. Registered read, one access per cycle.
module bhtoc_mem import bhtoc_pkg::*; #(
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 1024,
  parameter int PW     = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic              pay_we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [KEY_W-1:0]  wkey,
  input  logic              wlv,
  input  logic [ADDR_W-1:0] wlink,
  input  logic [PW-1:0]     wpay,
  output logic [KEY_W-1:0]  rkey,
  output logic              rlv,
  output logic [ADDR_W-1:0] rlink,
  output logic [PW-1:0]     rpay
);
  localparam int WORD_W = 1 + ADDR_W + KEY_W;

  logic [WORD_W-1:0] kmem [DEPTH];
  logic [PW-1:0]     pmem [DEPTH];
  logic [WORD_W-1:0] rword_r;
  logic [PW-1:0]     rpay_r;

  always_ff @(posedge clk) begin
    if (we) kmem[addr] <= {wlv, wlink, wkey};
    rword_r <= kmem[addr];
  end

  always_ff @(posedge clk) begin
    if (we && pay_we) pmem[addr] <= wpay;
    rpay_r <= pmem[addr];
  end

  assign rkey  = rword_r[KEY_W-1:0];
  assign rlink = rword_r[KEY_W+ADDR_W-1:KEY_W];
  assign rlv   = rword_r[WORD_W-1];
  assign rpay  = rpay_r;

endmodule

// File: design/bucket_hash_table_overflow_chain.sv
// Bucket hash table with overflow chaining: top level and sequencer.
// Depends on bhtoc_pkg, bhtoc_if, bhtoc_rem, bhtoc_mem and the defines header.
//
// in_ch carries opcode (insert/lookup), signed key and payload; out_ch returns
// one result per request: status, position, found payload, entries read.
// Transfers occur when valid and ready are both high. cfg_we/cfg_index/cfg_data
// write num_buckets (index 0) and bucket_slots (index 1); the user must write
// them only while idle; the block does not enforce this. Per request, ST_IDLE
// accepts, ST_DIV waits for the bit-serial remainder unit, ST_BASE forms
// bucket*slots, then ST_RD and ST_CHK read each record on the single-port
// store (slots scanned plus chain links followed); an insert adds a write in
// ST_WR_NEW, and one in ST_WR_TAIL when it links an overflow record; ST_DONE
// loads the output register. A zero key goes straight to ST_DONE. Lookups
// grow with the bucket and chain length. One request is in flight at a time.
// After reset a clearing pass writes every store entry (DEPTH entries, 1024
// at default sizes), with in_ch.ready low; config writes are still taken.
// The result sits in an output register; a stalled receiver holds it, and
// the next request may be accepted and processed, waiting only to hand off.
`include "bucket_hash_table_overflow_chain_defines.svh"

module bucket_hash_table_overflow_chain import bhtoc_pkg::*; #(
  parameter int MAX_BUCKETS    = 64,
  parameter int MAX_SLOTS      = 8,
  parameter int OVERFLOW_DEPTH = 512,
  parameter int PAYLOAD_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bhtoc_in_if.sink              in_ch,
  bhtoc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int OVF_BASE = MAX_BUCKETS * MAX_SLOTS;
  localparam int DEPTH    = OVF_BASE + OVERFLOW_DEPTH;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int USED_W   = $clog2(OVERFLOW_DEPTH + 1);
  localparam int PW       = PAYLOAD_BITS;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [NB_W-1:0] nb_r, ns_pad;
  logic [NS_W-1:0] ns_r;
  logic [NB_W-1:0] nb_eff;
  logic [NS_W-1:0] ns_eff;

  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]    pay_r, pay_nxt;
  logic [NB_W-1:0]  bucket_r, bucket_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [NS_W-1:0]  s_r, s_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [ADDR_W-1:0] new_addr_r, new_addr_nxt;
  logic [ADDR_W-1:0] tail_addr_r, tail_addr_nxt;
  logic [KEY_W-1:0] tail_key_r, tail_key_nxt;
  logic             need_tail_r, need_tail_nxt;

  logic [1:0]         res_stat_r, res_stat_nxt;
  logic [ADDR_W-1:0]  res_pos_r, res_pos_nxt;
  logic [PW-1:0]      res_pay_r, res_pay_nxt;
  logic [READS_W-1:0] reads_r, reads_nxt;

  logic               ov_r, ov_nxt;
  logic [1:0]         o_stat_r, o_stat_nxt;
  logic [POS_W-1:0]   o_pos_r, o_pos_nxt;
  logic [PW-1:0]      o_pay_r, o_pay_nxt;
  logic [READS_W-1:0] o_reads_r, o_reads_nxt;

  rem_req_t rreq;
  rem_rsp_t rrsp;

  logic              m_we, m_pay_we, m_lv;
  logic [ADDR_W-1:0] m_addr, m_link;
  logic [KEY_W-1:0]  m_key;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_lv;
  logic [ADDR_W-1:0] rd_link;
  logic [PW-1:0]     rd_pay;

  logic              accept, more_slots, pool_full;
  logic [ADDR_W-1:0] fresh, next_slot;
  logic [NB_W+NS_W-1:0] prod;

  bhtoc_rem u_rem (.clk(clk), .rst_n(rst_n), .req(rreq), .rsp(rrsp));

  bhtoc_mem #(.ADDR_W(ADDR_W), .DEPTH(DEPTH), .PW(PW)) u_mem (
    .clk(clk), .we(m_we), .pay_we(m_pay_we), .addr(m_addr), .wkey(m_key),
    .wlv(m_lv), .wlink(m_link), .wpay(pay_r), .rkey(rd_key), .rlv(rd_lv),
    .rlink(rd_link), .rpay(rd_pay)
  );

  assign ns_pad = NB_W'(ns_r);
  always_comb begin
    if (nb_r == '0) nb_eff = NB_W'(1);
    else if (32'(nb_r) > MAX_BUCKETS) nb_eff = NB_W'(MAX_BUCKETS);
    else nb_eff = nb_r;
    if (ns_r == '0) ns_eff = NS_W'(1);
    else if (32'(ns_pad) > MAX_SLOTS) ns_eff = NS_W'(MAX_SLOTS);
    else ns_eff = ns_r;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fresh       = ADDR_W'(OVF_BASE) + ADDR_W'(used_r);
  assign pool_full   = 32'(used_r) >= OVERFLOW_DEPTH;
  assign more_slots  = ({1'b0, s_r} + 1'b1) < {1'b0, ns_eff};
  assign next_slot   = base_r + ADDR_W'(s_r) + ADDR_W'(1);
  assign prod        = bucket_r * ns_eff;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    bucket_nxt    = bucket_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    s_nxt         = s_r;
    clr_nxt       = clr_r;
    used_nxt      = used_r;
    new_addr_nxt  = new_addr_r;
    tail_addr_nxt = tail_addr_r;
    tail_key_nxt  = tail_key_r;
    need_tail_nxt = need_tail_r;
    res_stat_nxt  = res_stat_r;
    res_pos_nxt   = res_pos_r;
    res_pay_nxt   = res_pay_r;
    reads_nxt     = reads_r;
    o_stat_nxt    = o_stat_r;
    o_pos_nxt     = o_pos_r;
    o_pay_nxt     = o_pay_r;
    o_reads_nxt   = o_reads_r;
    ov_nxt        = ov_r && !out_ch.ready;
    rreq.start    = 1'b0;
    rreq.neg      = in_ch.key[KEY_W-1];
    rreq.mag      = in_ch.key[KEY_W-1] ? -in_ch.key : in_ch.key;
    rreq.div      = nb_eff;
    m_we          = 1'b0;
    m_pay_we      = 1'b0;
    m_addr        = addr_r;
    m_key         = key_r;
    m_lv          = 1'b0;
    m_link        = new_addr_r;

    unique case (state_r)
      ST_CLEAR: begin
        m_we   = 1'b1;
        m_addr = clr_r;
        m_key  = '0;
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
        else clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_ch.opcode;
          key_nxt      = in_ch.key;
          pay_nxt      = in_ch.payload;
          res_stat_nxt = STAT_OK;
          res_pos_nxt  = '0;
          res_pay_nxt  = '0;
          reads_nxt    = '0;
          need_tail_nxt = 1'b0;
          if (in_ch.key == '0) begin
            res_stat_nxt = STAT_KEYZERO;
            state_nxt    = ST_DONE;
          end else begin
            rreq.start = 1'b1;
            state_nxt  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rrsp.done) begin
          bucket_nxt = rrsp.bucket;
          state_nxt  = ST_BASE;
        end
      end
      ST_BASE: begin
        base_nxt  = ADDR_W'(prod);
        addr_nxt  = ADDR_W'(prod);
        s_nxt     = '0;
        phase_nxt = (op_r == OP_INSERT) ? PH_SCAN : PH_LOOK;
        state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_CHK;
      ST_CHK: begin
        unique case (phase_r)
          PH_SCAN, PH_TAIL: begin
            if (phase_r == PH_SCAN && rd_key == '0) begin
              new_addr_nxt = addr_r;
              state_nxt    = ST_WR_NEW;
            end else if (phase_r == PH_SCAN && more_slots) begin
              s_nxt     = s_r + 1'b1;
              addr_nxt  = next_slot;
              state_nxt = ST_RD;
            end else if (phase_r == PH_SCAN && pool_full) begin
              res_stat_nxt = STAT_FULL;
              state_nxt    = ST_DONE;
            end else if (rd_lv) begin
              // walk to the chain tail; the last slot's link is already in hand
              phase_nxt = PH_TAIL;
              addr_nxt  = rd_link;
              state_nxt = ST_RD;
            end else begin
              tail_addr_nxt = addr_r;
              tail_key_nxt  = rd_key;
              new_addr_nxt  = fresh;
              need_tail_nxt = 1'b1;
              state_nxt     = ST_WR_NEW;
            end
          end
          PH_LOOK: begin
            if (reads_r != '1) reads_nxt = reads_r + 1'b1;
            if (rd_key == key_r) begin
              res_pos_nxt = addr_r;
              res_pay_nxt = rd_pay;
              state_nxt   = ST_DONE;
            end else if (rd_lv) begin
              addr_nxt  = rd_link;
              state_nxt = ST_RD;
            end else if (more_slots) begin
              s_nxt     = s_r + 1'b1;
              addr_nxt  = next_slot;
              state_nxt = ST_RD;
            end else begin
              res_stat_nxt = STAT_NOTFOUND;
              state_nxt    = ST_DONE;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_WR_NEW: begin
        m_we        = 1'b1;
        m_pay_we    = 1'b1;
        m_addr      = new_addr_r;
        res_pos_nxt = new_addr_r;
        if (need_tail_r) begin
          used_nxt  = used_r + 1'b1;
          state_nxt = ST_WR_TAIL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WR_TAIL: begin
        m_we      = 1'b1;
        m_addr    = tail_addr_r;
        m_key     = tail_key_r;
        m_lv      = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt      = 1'b1;
          o_stat_nxt  = res_stat_r;
          o_pos_nxt   = POS_W'(res_pos_r);
          o_pay_nxt   = res_pay_r;
          o_reads_nxt = reads_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
      nb_r    <= NB_RESET;
      ns_r    <= NS_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_BUCKETS:  nb_r <= cfg_data;
          REG_BUCKET_SLOTS: ns_r <= cfg_data[NS_W-1:0];
          default: ;
        endcase
      end
    end
    phase_r     <= phase_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    pay_r       <= pay_nxt;
    bucket_r    <= bucket_nxt;
    base_r      <= base_nxt;
    addr_r      <= addr_nxt;
    s_r         <= s_nxt;
    new_addr_r  <= new_addr_nxt;
    tail_addr_r <= tail_addr_nxt;
    tail_key_r  <= tail_key_nxt;
    need_tail_r <= need_tail_nxt;
    res_stat_r  <= res_stat_nxt;
    res_pos_r   <= res_pos_nxt;
    res_pay_r   <= res_pay_nxt;
    reads_r     <= reads_nxt;
    o_stat_r    <= o_stat_nxt;
    o_pos_r     <= o_pos_nxt;
    o_pay_r     <= o_pay_nxt;
    o_reads_r   <= o_reads_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.status        = o_stat_r;
  assign out_ch.position      = o_pos_r;
  assign out_ch.found_payload = o_pay_r;
  assign out_ch.entries_read  = o_reads_r;

  `BHTOC_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_ch.ready)
  `BHTOC_ASSERT_NOW(a_pool_bound, clk, rst_n, 1'b1, 32'(used_r) <= OVERFLOW_DEPTH)
  `BHTOC_ASSERT_NOW(a_rem_done_in_div, clk, rst_n, rrsp.done, state_r == ST_DIV)
  `BHTOC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != ST_IDLE)

endmodule

// File: sim/bucket_hash_table_overflow_chain_tb.sv
// Self-checking testbench for the bucket hash table with overflow chaining.
// Depends on bhtoc_pkg, bhtoc_if and the bucket_hash_table_overflow_chain RTL.
// A scoreboard class keeps its own copy of the table and checks every result.
module bucket_hash_table_overflow_chain_tb;
  import bhtoc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_B      = 64;
  localparam int MAX_S      = 8;
  localparam int OVF_DEPTH  = 512;
  localparam int OVF_BASE   = MAX_B * MAX_S;
  localparam int DEPTH      = OVF_BASE + OVF_DEPTH;
  localparam int READS_SAT  = 1023;
  localparam int NO_NEXT    = -1;
  localparam longint LIMIT  = 5_000_000;

  typedef struct {
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [31:0]        found_payload;
    logic [READS_W-1:0] entries_read;
  } table_answer_t;

  class hash_table_checker;
    logic [31:0] keys [DEPTH];
    logic [31:0] pays [DEPTH];
    int          links[DEPTH];
    int          ovf_used;
    logic [NB_W-1:0] nb_reg;
    logic [NS_W-1:0] ns_reg;
    table_answer_t answers[$];
    int mismatches;
    int checked;
    int hits, misses, fulls, zeros, overflows;

    function new();
      foreach (keys[i]) begin
        keys[i] = '0;
        pays[i] = '0;
        links[i] = NO_NEXT;
      end
      ovf_used = 0;
      nb_reg = NB_RESET;
      ns_reg = NS_RESET;
      mismatches = 0;
      checked = 0;
      hits = 0; misses = 0; fulls = 0; zeros = 0; overflows = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_NUM_BUCKETS) nb_reg = d[NB_W-1:0];
      else ns_reg = d[NS_W-1:0];
    endfunction

    // computes the answer of one accepted request and updates the table copy
    function void note_request(logic op, logic [31:0] key, logic [31:0] pay);
      table_answer_t a;
      int m, ns, base, s, p, st, tail, fresh, rd;
      longint k, h;
      bit hit;
      a.status = STAT_OK;
      a.position = '0;
      a.found_payload = '0;
      a.entries_read = '0;
      m = (nb_reg < 1) ? 1 : (nb_reg > MAX_B) ? MAX_B : int'(nb_reg);
      ns = (ns_reg < 1) ? 1 : (ns_reg > MAX_S) ? MAX_S : int'(ns_reg);
      if (key == 0) begin
        a.status = STAT_KEYZERO;
        zeros++;
      end else begin
        k = longint'($signed(key));
        h = k % m;
        if (h < 0) h += m;
        base = int'(h) * ns;
        if (op == OP_INSERT) begin
          for (s = 0; s < ns; s++)
            if (keys[base+s] == 0) break;
          if (s < ns) begin
            p = base + s;
            keys[p] = key;
            pays[p] = pay;
            links[p] = NO_NEXT;
            a.position = POS_W'(p);
          end else if (ovf_used >= OVF_DEPTH) begin
            a.status = STAT_FULL;
            fulls++;
          end else begin
            tail = base + ns - 1;
            fresh = OVF_BASE + ovf_used;
            for (st = 0; st < OVF_DEPTH; st++) begin
              if (links[tail] < 0) break;
              tail = links[tail];
            end
            keys[fresh] = key;
            pays[fresh] = pay;
            links[fresh] = NO_NEXT;
            links[tail] = fresh;
            ovf_used++;
            overflows++;
            a.position = POS_W'(fresh);
          end
        end else begin
          hit = 0;
          rd = 0;
          p = 0;
          for (s = 0; s < ns && !hit; s++) begin
            p = base + s;
            if (rd < READS_SAT) rd++;
            if (keys[p] == key) begin
              hit = 1;
              break;
            end
            // slots may carry chains left behind by earlier settings
            for (st = 0; st < OVF_DEPTH; st++) begin
              p = links[p];
              if (p < 0) break;
              if (rd < READS_SAT) rd++;
              if (keys[p] == key) begin
                hit = 1;
                break;
              end
            end
          end
          a.entries_read = READS_W'(rd);
          if (hit) begin
            a.position = POS_W'(p);
            a.found_payload = pays[p];
            hits++;
          end else begin
            a.status = STAT_NOTFOUND;
            misses++;
          end
        end
      end
      answers = {answers, a};
    endfunction

    function void check_result(logic [1:0] status, logic [POS_W-1:0] pos,
                               logic [31:0] fp, logic [READS_W-1:0] rd);
      table_answer_t a;
      checked++;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d pos %0d payload %h reads %0d",
                   status, pos, fp, rd);
        return;
      end
      a = answers.pop_front();
      if (status !== a.status || pos !== a.position || fp !== a.found_payload ||
          rd !== a.entries_read) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp status %0d pos %0d payload %h reads %0d, got %0d %0d %h %0d",
                   checked, a.status, a.position, a.found_payload, a.entries_read,
                   status, pos, fp, rd);
      end
    endfunction

    function int pending();
      return answers.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bhtoc_in_if  in_ch();
  bhtoc_out_if out_ch();

  bucket_hash_table_overflow_chain dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hash_table_checker sb;
  logic [31:0] recent_keys[$];
  int burst_left;
  int results_seen;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // result monitor: signals are stable at the falling edge, transfer at the next rise
  initial begin
    results_seen = 0;
    forever begin
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.status, out_ch.position, out_ch.found_payload,
                        out_ch.entries_read);
        results_seen++;
      end
    end
  end

  // receiver back-pressure: changing modes plus one long hold-off
  initial begin
    int mode, left, i;
    bit held;
    out_ch.ready <= 1'b0;
    held = 0;
    mode = 0;
    left = 0;
    i = 0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      i++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 99) < 70);
        2: out_ch.ready <= ((i % 7) < 2);
        default: out_ch.ready <= ($urandom_range(0, 99) < 20);
      endcase
    end
  end

  task automatic send_item(logic op, logic [31:0] key, logic [31:0] pay);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.key     <= key;
    in_ch.payload <= pay;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sb.note_request(op, key, pay);
    if (op == OP_INSERT && key != 0) begin
      recent_keys = {recent_keys, key};
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] nb, logic [CFG_DATA_W-1:0] ns);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_BUCKETS;
    cfg_data  <= nb;
    @(posedge clk);
    sb.write_reg(REG_NUM_BUCKETS, nb);
    cfg_index <= REG_BUCKET_SLOTS;
    cfg_data  <= ns;
    @(posedge clk);
    sb.write_reg(REG_BUCKET_SLOTS, ns);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h0;
    if (r < 45 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 75) return 32'($signed($urandom_range(0, 400)) - 200);
    if (r < 80) return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic random_items(int n, int insert_pct);
    logic op;
    repeat (n) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
      send_item(op, pick_key(), $urandom);
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_NUM_BUCKETS;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_INSERT;
    in_ch.key <= '0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero key, duplicates, a bucket spilling into the pool
    send_item(OP_INSERT, 32'h0000_0001, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
    send_item(OP_INSERT, 32'h8000_0000, 32'h5A5A_A5A5);
    send_item(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0001, 32'hDEAD_BEEF);
    send_item(OP_LOOKUP, 32'h0000_0001, 32'h0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_LOOKUP, 32'h8000_0000, 32'h0);
    send_item(OP_LOOKUP, 32'h0000_0002, 32'h0);
    for (int i = 1; i <= 10; i++)
      send_item(OP_INSERT, 32'(i * 64), 32'(i));
    send_item(OP_LOOKUP, 32'(640), 32'h0);
    send_item(OP_LOOKUP, 32'(704), 32'h0);
    random_items(60, 50);
    drain();

    // one bucket of one slot: every insert walks the chain until the pool is full
    set_config(7'd1, 7'd1);
    for (int i = 0; i < 530; i++) begin
      if (i % 25 == 24) send_item(OP_LOOKUP, pick_key(), $urandom);
      else send_item(OP_INSERT, $urandom | 32'h1, $urandom);
    end
    drain();

    // registers out of range are saturated by the block, then in-range settings
    set_config(7'd0, 7'h7F);
    random_items(30, 40);
    drain();
    set_config(7'h7F, 7'd0);
    random_items(30, 40);
    drain();
    set_config(7'd13, 7'd5);
    random_items(60, 40);
    drain();
    set_config(7'd64, 7'd8);
    random_items(30, 40);
    drain();
    repeat (50) @(posedge clk);

    $display("checked %0d results: %0d hits, %0d misses, %0d overflow inserts,",
             sb.checked, sb.hits, sb.misses, sb.overflows);
    $display("%0d pool-full and %0d zero-key answers over six register settings",
             sb.fulls, sb.zeros);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+design
design/bhtoc_pkg.sv
design/bhtoc_if.sv
design/bhtoc_rem.sv
design/bhtoc_mem.sv
design/bucket_hash_table_overflow_chain.sv
sim/bucket_hash_table_overflow_chain_tb.sv
